// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define KCC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define KCC_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/kcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Keypad calculator package
// Key codes, operation codes, sequencer states and shared constants.
// ----------------------------------------------------------------------------
package kcc_pkg;

  localparam int DIGITS_DEF = 6;
  localparam int SHOWN      = 6;
  localparam int DATA_W     = 32;
  localparam int FUNC_W     = 3;
  localparam int CODE_W     = 4;

  localparam logic [CODE_W-1:0] BLANK     = 4'd10;
  localparam logic [CODE_W-1:0] DIGIT_MAX = 4'd9;

  typedef enum logic [FUNC_W-1:0] {
    FN_DIGIT  = 3'd0,
    FN_CLEAR  = 3'd1,
    FN_EQUALS = 3'd2,
    FN_ADD    = 3'd3,
    FN_SUB    = 3'd4,
    FN_MUL    = 3'd5,
    FN_DIV    = 3'd6
  } func_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIG_MUL,
    ST_DIG_ADD,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_RANGE,
    ST_CONV,
    ST_SHOW,
    ST_DONE
  } state_e;

  // 10^n, evaluated at elaboration
  function automatic logic [DATA_W-1:0] pow10(input int n);
    logic [DATA_W-1:0] v;
    v = 1;
    for (int i = 0; i < n; i++) begin
      v = DATA_W'(v * 10);
    end
    return v;
  endfunction

endpackage

// ===== hdl/keypad_calculator_controller.sv =====
// ----------------------------------------------------------------------------
// Keypad calculator controller
// Four-function decimal calculator driven by decoded key items.
// ----------------------------------------------------------------------------
// One key item in, one display/result item out. An accepted digit passes
// ST_DIG_MUL and ST_DIG_ADD; other keys go straight to ST_DONE, but equals
// runs on one shared 33-bit adder/subtractor through ST_EXEC, ST_RANGE and,
// if the result fits, the 32 shift steps of the binary-to-decimal conversion;
// multiply and a nonzero divide add the 32 one-bit steps of the shift-add
// multiply or restoring divide. The input stalls while a key is in work;
// a new key is taken while a finished result still waits on the output.
`include "assert_macros.svh"

module keypad_calculator_controller #(
  parameter int DIGITS = kcc_pkg::DIGITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [kcc_pkg::FUNC_W-1:0]   func_i,
  input  logic [kcc_pkg::CODE_W-1:0]   digit_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [kcc_pkg::CODE_W-1:0]   show0_o,
  output logic [kcc_pkg::CODE_W-1:0]   show1_o,
  output logic [kcc_pkg::CODE_W-1:0]   show2_o,
  output logic [kcc_pkg::CODE_W-1:0]   show3_o,
  output logic [kcc_pkg::CODE_W-1:0]   show4_o,
  output logic [kcc_pkg::CODE_W-1:0]   show5_o,
  output logic [kcc_pkg::DATA_W-1:0]   answer_o,
  output logic                         too_wide_o,
  output logic                         zero_divisor_o
);
  import kcc_pkg::*;

  localparam int CW    = $clog2(DIGITS + 1);
  localparam int BW    = CODE_W * DIGITS;
  localparam int CNT_W = $clog2(DATA_W);
  localparam logic [DATA_W-1:0] LIMIT = pow10(DIGITS);

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [DATA_W-1:0]   entry_q, entry_d;
  logic [DATA_W-1:0]   first_q, first_d;
  logic [DATA_W-1:0]   result_q, result_d;
  op_e                 pend_q, pend_d;
  logic [CODE_W-1:0]   disp_q [DIGITS];
  logic [CODE_W-1:0]   disp_d [DIGITS];
  logic                wide_q, wide_d;
  logic                zdiv_q, zdiv_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;

  logic [CODE_W-1:0]   dv_q, dv_d;
  logic [DATA_W-1:0]   acc_q, acc_d;
  logic [DATA_W-1:0]   opa_q, opa_d;
  logic [DATA_W-1:0]   opb_q, opb_d;
  logic [BW-1:0]       bcd_q, bcd_d;
  logic [CODE_W-1:0]   show_q [SHOWN];
  logic [CODE_W-1:0]   show_d [SHOWN];
  logic [DATA_W-1:0]   answer_q, answer_d;
  logic                out_wide_q, out_wide_d;
  logic                out_zdiv_q, out_zdiv_d;

  logic [DATA_W:0]     alu_a, alu_b;
  logic                alu_sub;
  logic [DATA_W+1:0]   alu_sum;
  logic [BW-1:0]       bcd_adj;
  logic [CW-1:0]       show_n;
  logic [CODE_W-1:0]   conv_disp [DIGITS];
  logic [CODE_W-1:0]   disp_ext [SHOWN];
  logic                last_step;

  // shared adder/subtractor
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      ST_DIG_MUL: begin
        alu_a = {1'b0, entry_q[DATA_W-4:0], 3'b000};
        alu_b = {1'b0, entry_q[DATA_W-2:0], 1'b0};
      end
      ST_DIG_ADD: begin
        alu_a = {1'b0, acc_q};
        alu_b = {{(DATA_W + 1 - CODE_W){1'b0}}, dv_q};
      end
      ST_EXEC: begin
        alu_a   = {1'b0, opa_q};
        alu_b   = {1'b0, opb_q};
        alu_sub = (pend_q == OP_SUB);
      end
      ST_MUL: begin
        alu_a = {1'b0, acc_q};
        alu_b = opb_q[0] ? {1'b0, opa_q} : '0;
      end
      ST_DIV: begin
        alu_a   = {acc_q, opa_q[DATA_W-1]};
        alu_b   = {1'b0, opb_q};
        alu_sub = 1'b1;
      end
      ST_RANGE: begin
        alu_a   = {1'b0, result_q};
        alu_b   = {1'b0, LIMIT};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {(DATA_W + 1){alu_sub}}}
                 + {{(DATA_W + 1){1'b0}}, alu_sub};

  assign last_step = (cnt_q == CNT_W'(DATA_W - 1));

  // double-dabble correction per decimal digit
  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      if (bcd_q[CODE_W*k +: CODE_W] >= 4'd5) begin
        bcd_adj[CODE_W*k +: CODE_W] = bcd_q[CODE_W*k +: CODE_W] + 4'd3;
      end else begin
        bcd_adj[CODE_W*k +: CODE_W] = bcd_q[CODE_W*k +: CODE_W];
      end
    end
  end

  // left-aligned display from the decimal digits
  always_comb begin
    show_n = CW'(1);
    for (int k = 1; k < DIGITS; k++) begin
      if (bcd_q[CODE_W*k +: CODE_W] != '0) begin
        show_n = CW'(k + 1);
      end
    end
    for (int p = 0; p < DIGITS; p++) begin
      conv_disp[p] = BLANK;
      for (int k = 0; k < DIGITS; k++) begin
        if (k + p + 1 == int'(show_n)) begin
          conv_disp[p] = bcd_q[CODE_W*k +: CODE_W];
        end
      end
    end
  end

  for (genvar g = 0; g < SHOWN; g++) begin : g_ext
    if (g < DIGITS) begin : g_pos
      assign disp_ext[g] = disp_q[g];
    end else begin : g_blank
      assign disp_ext[g] = BLANK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      entry_q     <= '0;
      first_q     <= '0;
      result_q    <= '0;
      pend_q      <= OP_NONE;
      wide_q      <= 1'b0;
      zdiv_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int p = 0; p < DIGITS; p++) begin
        disp_q[p] <= BLANK;
      end
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      entry_q     <= entry_d;
      first_q     <= first_d;
      result_q    <= result_d;
      pend_q      <= pend_d;
      wide_q      <= wide_d;
      zdiv_q      <= zdiv_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      disp_q      <= disp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q       <= dv_d;
    acc_q      <= acc_d;
    opa_q      <= opa_d;
    opb_q      <= opb_d;
    bcd_q      <= bcd_d;
    show_q     <= show_d;
    answer_q   <= answer_d;
    out_wide_q <= out_wide_d;
    out_zdiv_q <= out_zdiv_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    entry_d     = entry_q;
    first_d     = first_q;
    result_d    = result_q;
    pend_d      = pend_q;
    disp_d      = disp_q;
    wide_d      = wide_q;
    zdiv_d      = zdiv_q;
    cnt_d       = cnt_q;
    dv_d        = dv_q;
    acc_d       = acc_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    bcd_d       = bcd_q;
    show_d      = show_q;
    answer_d    = answer_q;
    out_wide_d  = out_wide_q;
    out_zdiv_d  = out_zdiv_q;
    out_valid_d = out_valid_q & out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          wide_d  = 1'b0;
          zdiv_d  = 1'b0;
          dv_d    = digit_value_i;
          state_d = ST_DONE;
          case (func_e'(func_i))
            FN_DIGIT: begin
              if (count_q < CW'(DIGITS) && digit_value_i <= DIGIT_MAX) begin
                for (int p = 0; p < DIGITS; p++) begin
                  if (p == int'(count_q)) begin
                    disp_d[p] = digit_value_i;
                  end else if (p > int'(count_q)) begin
                    disp_d[p] = BLANK;
                  end
                end
                count_d = count_q + 1'b1;
                state_d = ST_DIG_MUL;
              end
            end
            FN_CLEAR: begin
              count_d  = '0;
              entry_d  = '0;
              first_d  = '0;
              result_d = '0;
              pend_d   = OP_NONE;
              for (int p = 0; p < DIGITS; p++) begin
                disp_d[p] = BLANK;
              end
            end
            FN_EQUALS: begin
              opa_d   = first_q;
              opb_d   = (count_q != '0) ? entry_q : result_q;
              count_d = '0;
              entry_d = '0;
              state_d = ST_EXEC;
            end
            FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
              if (count_q != '0) begin
                first_d = entry_q;
              end
              case (func_e'(func_i))
                FN_ADD:  pend_d = OP_ADD;
                FN_SUB:  pend_d = OP_SUB;
                FN_MUL:  pend_d = OP_MUL;
                default: pend_d = OP_DIV;
              endcase
              count_d = '0;
              entry_d = '0;
              for (int p = 0; p < DIGITS; p++) begin
                disp_d[p] = BLANK;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_DIG_MUL: begin
        acc_d   = alu_sum[DATA_W-1:0];
        state_d = ST_DIG_ADD;
      end
      ST_DIG_ADD: begin
        entry_d = alu_sum[DATA_W-1:0];
        state_d = ST_DONE;
      end
      ST_EXEC: begin
        pend_d = OP_NONE;
        cnt_d  = '0;
        acc_d  = '0;
        case (pend_q)
          OP_ADD, OP_SUB: begin
            result_d = alu_sum[DATA_W-1:0];
            state_d  = ST_RANGE;
          end
          OP_MUL: begin
            state_d = ST_MUL;
          end
          OP_DIV: begin
            if (opb_q == '0) begin
              result_d = '1;
              zdiv_d   = 1'b1;
              state_d  = ST_RANGE;
            end else begin
              state_d = ST_DIV;
            end
          end
          default: begin
            result_d = opb_q;
            state_d  = ST_RANGE;
          end
        endcase
      end
      ST_MUL: begin
        acc_d = alu_sum[DATA_W-1:0];
        opa_d = {opa_q[DATA_W-2:0], 1'b0};
        opb_d = {1'b0, opb_q[DATA_W-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (last_step) begin
          result_d = alu_sum[DATA_W-1:0];
          state_d  = ST_RANGE;
        end
      end
      ST_DIV: begin
        acc_d = alu_sum[DATA_W+1] ? alu_sum[DATA_W-1:0]
                                  : {acc_q[DATA_W-2:0], opa_q[DATA_W-1]};
        opa_d = {opa_q[DATA_W-2:0], alu_sum[DATA_W+1]};
        cnt_d = cnt_q + 1'b1;
        if (last_step) begin
          result_d = {opa_q[DATA_W-2:0], alu_sum[DATA_W+1]};
          state_d  = ST_RANGE;
        end
      end
      ST_RANGE: begin
        if (alu_sum[DATA_W+1]) begin
          wide_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          bcd_d   = '0;
          opa_d   = result_q;
          cnt_d   = '0;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (BW > 1) begin
          bcd_d = {bcd_adj[BW-2:0], opa_q[DATA_W-1]};
        end
        opa_d = {opa_q[DATA_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (last_step) begin
          state_d = ST_SHOW;
        end
      end
      ST_SHOW: begin
        disp_d  = conv_disp;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          show_d      = disp_ext;
          answer_d    = result_q;
          out_wide_d  = wide_q;
          out_zdiv_d  = zdiv_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign show0_o        = show_q[0];
  assign show1_o        = show_q[1];
  assign show2_o        = show_q[2];
  assign show3_o        = show_q[3];
  assign show4_o        = show_q[4];
  assign show5_o        = show_q[5];
  assign answer_o       = answer_q;
  assign too_wide_o     = out_wide_q;
  assign zero_divisor_o = out_zdiv_q;

  `KCC_ASSERT(a_zdiv_wide, clk_i, rst_ni, out_valid_o && zero_divisor_o |-> too_wide_o && (answer_o == '1), "divide by zero item not flagged wide or not all ones")
  `KCC_ASSERT_ALWAYS(a_count_bound, clk_i, !rst_ni || count_q <= CW'(DIGITS), "digit count beyond display width")
  `KCC_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o, "no work started after item accepted")
  `KCC_ASSERT(a_done_emits, clk_i, rst_ni, state_q == ST_DONE && !out_valid_q |=> out_valid_o, "finished item not presented")

endmodule
